// ===== hw/rtl/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sd_pkg
// types, constants and helper functions shared by the utf-8 stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sd_pkg;

    localparam int unsigned CP_W    = 31;
    localparam int unsigned OFS_W   = 16;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned LEN_W   = 3;

    localparam logic [CP_W-1:0]  MAX_UNICODE   = 31'h0010_FFFF;
    localparam logic [CP_W-1:0]  SURR_LO       = 31'h0000_D800;
    localparam logic [CP_W-1:0]  SURR_HI       = 31'h0000_DFFF;
    localparam logic [CNT_W-1:0] COUNT_MAX     = 17'h1_0000;
    localparam logic [7:0]       CONT_MASK     = 8'hC0;
    localparam logic [7:0]       CONT_TAG      = 8'h80;
    localparam logic [7:0]       PAYLOAD_MASK  = 8'h3F;
    localparam logic [7:0]       LEAD_BAD_MIN  = 8'hFE;

    // per-string decoder state
    typedef struct packed {
        logic [CP_W-1:0]  acc;
        logic [LEN_W-1:0] remaining;
        logic [LEN_W-1:0] seq_len;
        logic [OFS_W-1:0] char_start;
        logic [CNT_W-1:0] decoded_count;
        logic             dropping;
    } t_state;

    // one result transaction
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [OFS_W-1:0] start_offset;
        logic [CNT_W-1:0] char_count;
        logic             is_error;
        logic             end_of_string;
    } t_result;

    // smallest legal value for a sequence of the given length
    function automatic logic [CP_W-1:0] min_value(input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] v;
        case (len)
            3'd2: v = 31'h0000_0080;
            3'd3: v = 31'h0000_0800;
            3'd4: v = 31'h0001_0000;
            3'd5: v = 31'h0020_0000;
            3'd6: v = 31'h0400_0000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utf8sd_byte_if.sv =====
// ----------------------------------------------------------------------------
// utf8sd_byte_if
// byte channel into the decoder: valid/ready with byte and last flag
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8sd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/utf8sd_result_if.sv =====
// ----------------------------------------------------------------------------
// utf8sd_result_if
// result channel out of the decoder: valid/ready with decoded character
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8sd_result_if;
    logic                           valid;
    logic                           ready;
    logic [utf8sd_pkg::CP_W-1:0]    code_point;
    logic [utf8sd_pkg::OFS_W-1:0]   start_offset;
    logic [utf8sd_pkg::CNT_W-1:0]   char_count;
    logic                           is_error;
    logic                           end_of_string;

    modport source (output valid, output code_point, output start_offset,
                    output char_count, output is_error, output end_of_string,
                    input ready);
    modport sink   (input valid, input code_point, input start_offset,
                    input char_count, input is_error, input end_of_string,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/utf8sd_decode.sv =====
// ----------------------------------------------------------------------------
// utf8sd_decode
// next-state and result logic for one byte of an extended utf-8 stream
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_decode (
    input  wire utf8sd_pkg::t_state  i_state,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_last,
    input  wire logic                i_strict,
    input  wire logic [15:0]         i_pos,
    output utf8sd_pkg::t_state       o_next,
    output utf8sd_pkg::t_result      o_res,
    output logic                     o_res_valid
);
    import utf8sd_pkg::*;

    logic            is_cont;
    logic [2:0]      lead_k;
    logic [7:0]      lead_mask;
    logic [CP_W-1:0] shifted;
    logic            do_complete;
    logic            do_fail;
    logic            bad;
    logic [CP_W-1:0] cv;
    logic [LEN_W-1:0] clen;

    assign is_cont = (i_byte & CONT_MASK) == CONT_TAG;
    assign shifted = {i_state.acc[CP_W-7:0], i_byte[5:0]};

    // continuation count and payload mask of a lead byte
    always_comb begin
        if (i_byte[7:5] == 3'b110) begin
            lead_k = 3'd1; lead_mask = 8'h1F;
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_k = 3'd2; lead_mask = 8'h0F;
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_k = 3'd3; lead_mask = 8'h07;
        end else if (i_byte[7:2] == 6'b111110) begin
            lead_k = 3'd4; lead_mask = 8'h03;
        end else begin
            lead_k = 3'd5; lead_mask = 8'h01;
        end
    end

    always_comb begin
        o_next      = i_state;
        do_complete = 1'b0;
        do_fail     = 1'b0;
        cv          = '0;
        clen        = '0;
        bad         = 1'b0;

        if (i_state.dropping) begin
            // nothing decoded, last byte repeats the error below
        end else if (i_state.remaining == '0) begin
            o_next.char_start = i_pos;
            if (!i_byte[7]) begin
                do_complete = 1'b1;
                cv          = {23'd0, i_byte};
                clen        = 3'd1;
            end else if (is_cont || i_byte >= LEAD_BAD_MIN) begin
                do_fail = 1'b1;
            end else begin
                o_next.acc       = {23'd0, i_byte & lead_mask};
                o_next.remaining = lead_k;
                o_next.seq_len   = lead_k + 3'd1;
                do_fail          = i_last;
            end
        end else begin
            if (!is_cont) begin
                do_fail = 1'b1;
            end else begin
                o_next.acc       = shifted;
                o_next.remaining = i_state.remaining - 3'd1;
                if (i_state.remaining == 3'd1) begin
                    do_complete = 1'b1;
                    cv          = shifted;
                    clen        = i_state.seq_len;
                end else begin
                    do_fail = i_last;
                end
            end
        end

        if (do_complete) begin
            bad = (cv < min_value(clen))
                || (i_strict && ((cv > MAX_UNICODE) || (cv >= SURR_LO && cv <= SURR_HI)));
            if (bad) begin
                do_fail     = 1'b1;
                do_complete = 1'b0;
            end else begin
                if (i_state.decoded_count < COUNT_MAX) begin
                    o_next.decoded_count = i_state.decoded_count + 17'd1;
                end
                o_next.remaining = '0;
                o_next.seq_len   = '0;
                o_next.acc       = '0;
            end
        end

        if (do_fail) begin
            o_next.dropping  = 1'b1;
            o_next.remaining = '0;
            o_next.seq_len   = '0;
            o_next.acc       = '0;
        end

        o_res.code_point    = do_complete ? cv : '0;
        o_res.start_offset  = o_next.char_start;
        o_res.char_count    = o_next.decoded_count;
        o_res.is_error      = !do_complete;
        o_res.end_of_string = i_last;
        o_res_valid         = do_complete || do_fail || (i_state.dropping && i_last);

        // every string leaves the state as after reset
        if (i_last) begin
            o_next = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// extended utf-8 stream decoder, one byte per clock unless the result side stalls, one to six byte forms
// ----------------------------------------------------------------------------
// A byte is taken into an input register, decoded against the per-string
// state combinationally and its result, if any, lands in an output register.
// The unit takes one byte per clock while the result side keeps up; an accepted
// byte reaches its result transaction through the input and result registers.
// Ready drops only while both registers hold data and the result side stalls.
// Strict mode (reset value 1) is written through i_cfg_we / i_cfg_wdata.
`default_nettype none

module utf8_stream_decoder_unit #(
    parameter longint unsigned MAX_STRING_BYTES = 65536
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    utf8sd_byte_if.sink            i_byte_ch,
    utf8sd_result_if.source        o_result_ch
);
    import utf8sd_pkg::*;

    // byte offset wraps at the string limit, and never beyond 16 bits
    localparam longint unsigned POS_WRAP =
        (MAX_STRING_BYTES > 64'd65536) ? 64'd65536 : MAX_STRING_BYTES;
    localparam logic [OFS_W-1:0] POS_LAST = OFS_W'(POS_WRAP - 64'd1);

    // configuration
    logic r_strict;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // per-string state
    t_state           r_state, n_state;
    logic [OFS_W-1:0] r_pos, n_pos;

    // result register
    logic    r_out_valid;
    t_result r_out, n_out;
    logic    n_out_valid;

    logic s1_adv;
    logic in_take;

    // the decode stage moves when the result slot is free or being emptied
    assign s1_adv  = r_s1_valid && (!r_out_valid || o_result_ch.ready);
    assign in_take = i_byte_ch.valid && i_byte_ch.ready;
    assign i_byte_ch.ready = !r_s1_valid || s1_adv;

    assign n_pos = (r_s1_last || r_pos == POS_LAST) ? '0 : r_pos + 16'd1;

    utf8sd_decode u_decode (
        .i_state     (r_state),
        .i_byte      (r_s1_byte),
        .i_last      (r_s1_last),
        .i_strict    (r_strict),
        .i_pos       (r_pos),
        .o_next      (n_state),
        .o_res       (n_out),
        .o_res_valid (n_out_valid)
    );

    // strict mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
        end else if (i_cfg_we) begin
            r_strict <= i_cfg_wdata;
        end
    end

    // input register: refilled on every byte transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_byte_ch.ready) begin
            r_s1_valid <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_byte_ch.data_byte;
            r_s1_last <= i_byte_ch.last;
        end
    end

    // decoder state only moves when a byte leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_pos   <= '0;
        end else if (s1_adv) begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= n_out_valid;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_result_ch.valid         = r_out_valid;
    assign o_result_ch.code_point    = r_out.code_point;
    assign o_result_ch.start_offset  = r_out.start_offset;
    assign o_result_ch.char_count    = r_out.char_count;
    assign o_result_ch.is_error      = r_out.is_error;
    assign o_result_ch.end_of_string = r_out.end_of_string;

`ifndef SYNTHESIS
    // a last byte always leaves a result behind it
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_last |=> r_out_valid && r_out.end_of_string)
        else $error("last byte produced no end-of-string result");

    // a finished string leaves the decoder as after reset
    a_string_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_last |=> r_state == '0 && r_pos == '0)
        else $error("per-string state not cleared after last byte");

    // error transactions carry no code point
    a_error_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_error |-> r_out.code_point == '0)
        else $error("error result with non-zero code point");

    // character count saturates
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.decoded_count <= COUNT_MAX)
        else $error("character count beyond saturation value");
`endif

endmodule

`default_nettype wire
